### hdl/hcgas_pkg.sv
// Shared constants, types and helpers for the hit-count grid with active-cell list.
package hcgas_pkg;

    localparam int GRID_SIDE_LOG2 = 6;
    localparam int COUNT_BITS     = 16;
    localparam int CELL_BITS      = 2 * GRID_SIDE_LOG2;
    localparam int CELLS          = 1 << CELL_BITS;
    localparam int SIZE_BITS      = CELL_BITS + 1;

    localparam int COORD_W     = 24;
    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 12;
    localparam int STATUS_W    = 3;
    localparam int HIT_OUT_W   = 16;
    localparam int TOTAL_W     = 13;
    localparam int SHIFT_W     = 4;
    localparam int CFG_INDEX_W = 2;

    typedef logic [COUNT_BITS-1:0]      count_t;
    typedef logic [CELL_BITS-1:0]       cell_t;
    typedef logic [SIZE_BITS-1:0]       size_t;
    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [KIND_W-1:0]          kind_t;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_SKIPPED   = 3'd1;
    localparam status_t ST_OUTSIDE   = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_BAD_INDEX = 3'd4;
    localparam status_t ST_SATURATED = 3'd5;

    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;
    localparam kind_t KIND_READ   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_SHIFT = 2'd2;

    localparam logic [SHIFT_W-1:0] CELL_SHIFT_RESET = 4'd4;

    function automatic logic [HIT_OUT_W-1:0] hit_out(input count_t c);
        logic [31:0] w;
        w = 32'(c);
        return w[HIT_OUT_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] total_out(input size_t s);
        logic [31:0] w;
        w = 32'(s);
        return w[TOTAL_W-1:0];
    endfunction

endpackage

### hdl/hit_count_grid_active_set.sv
// Steps: an add/remove is taken in S_IDLE, then goes through S_ADDR and S_EXEC into the
// result register; a list read adds S_LCNT. Only one item is in flight, and a stalled result port holds it, set by the
// read-modify-write through the single-port count, position and list memories.
// Reset: synchronous, active low; afterwards the count memory is cleared one entry per
// cycle over all 4096 entries (CELLS) with s_ready low; configuration writes are taken throughout.
module hit_count_grid_active_set
    import hcgas_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [KIND_W-1:0]      s_kind,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic                   s_finite,
    input  logic [INDEX_W-1:0]     s_list_index,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_W-1:0]    m_status,
    output logic signed [COORD_W-1:0] m_cell_x,
    output logic signed [COORD_W-1:0] m_cell_y,
    output logic [HIT_OUT_W-1:0]   m_hit_count,
    output logic [TOTAL_W-1:0]     m_active_total,
    output logic                   m_became_active,
    output logic                   m_became_inactive
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_LCNT  = 3'd4;

    localparam int LOG2 = GRID_SIDE_LOG2;

    // state and configuration
    logic [2:0]         state_reg, state_next;
    cell_t              clr_addr_reg, clr_addr_next;
    size_t              size_reg, size_next;
    coord_t             origin_x_reg, origin_y_reg;
    logic [SHIFT_W-1:0] shift_reg;

    // captured item
    kind_t              kind_reg;
    logic               finite_reg;
    logic [INDEX_W-1:0] index_reg;
    coord_t             cx_reg, cy_reg;
    status_t            pre_status_reg, pre_status_next;
    cell_t              flat_reg, flat_next;

    // memories
    count_t cnt_mem  [CELLS];
    cell_t  pos_mem  [CELLS];
    cell_t  list_mem [CELLS];

    logic   cnt_we, cnt_re, pos_we, pos_re, list_we, list_re;
    cell_t  cnt_waddr, cnt_raddr, pos_waddr, pos_raddr, list_waddr, list_raddr;
    count_t cnt_wdata;
    cell_t  pos_wdata, list_wdata;
    count_t cnt_rdata_reg;
    cell_t  pos_rdata_reg, list_rdata_reg;

    // result register
    logic    m_valid_reg, m_valid_next;
    status_t m_status_reg, m_status_next;
    coord_t  m_cell_x_reg, m_cell_x_next, m_cell_y_reg, m_cell_y_next;
    logic [HIT_OUT_W-1:0] m_hit_reg, m_hit_next;
    logic [TOTAL_W-1:0]   m_total_reg, m_total_next;
    logic    m_on_reg, m_on_next, m_off_reg, m_off_next;

    logic               out_free;
    logic signed [COORD_W:0] lx, ly;
    logic               in_window;
    count_t             c;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    assign lx = {cx_reg[COORD_W-1], cx_reg} - {origin_x_reg[COORD_W-1], origin_x_reg};
    assign ly = {cy_reg[COORD_W-1], cy_reg} - {origin_y_reg[COORD_W-1], origin_y_reg};
    assign in_window = (lx[COORD_W:LOG2] == '0) && (ly[COORD_W:LOG2] == '0);
    assign c = cnt_rdata_reg;

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        size_next       = size_reg;
        pre_status_next = pre_status_reg;
        flat_next       = flat_reg;

        cnt_we = 1'b0;  cnt_waddr  = flat_reg;  cnt_wdata  = '0;
        pos_we = 1'b0;  pos_waddr  = flat_reg;  pos_wdata  = '0;
        list_we = 1'b0; list_waddr = '0;        list_wdata = flat_reg;
        cnt_re = 1'b0;  cnt_raddr  = flat_reg;
        pos_re = 1'b0;  pos_raddr  = flat_reg;
        list_re = 1'b0; list_raddr = '0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_cell_x_next = m_cell_x_reg;
        m_cell_y_next = m_cell_y_reg;
        m_hit_next    = m_hit_reg;
        m_total_next  = m_total_reg;
        m_on_next     = m_on_reg;
        m_off_next    = m_off_reg;

        unique case (state_reg)
            S_CLEAR: begin
                cnt_we        = 1'b1;
                cnt_waddr     = clr_addr_reg;
                cnt_wdata     = '0;
                clr_addr_next = cell_t'(clr_addr_reg + cell_t'(1));
                if (clr_addr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                flat_next = {ly[LOG2-1:0], lx[LOG2-1:0]};
                if (kind_reg == KIND_READ) begin
                    pre_status_next = (32'(index_reg) < 32'(size_reg)) ? ST_OK : ST_BAD_INDEX;
                end else if (kind_reg != KIND_ADD && kind_reg != KIND_REMOVE || !finite_reg) begin
                    pre_status_next = ST_SKIPPED;
                end else if (!in_window) begin
                    pre_status_next = ST_OUTSIDE;
                end else begin
                    pre_status_next = ST_OK;
                end
                cnt_re     = 1'b1;
                cnt_raddr  = flat_next;
                pos_re     = 1'b1;
                pos_raddr  = flat_next;
                list_re    = 1'b1;
                list_raddr = (kind_reg == KIND_READ) ? cell_t'(index_reg)
                                                     : cell_t'(size_reg - size_t'(1));
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (pre_status_reg == ST_OK && kind_reg == KIND_READ) begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = list_rdata_reg;
                    flat_next  = list_rdata_reg;
                    state_next = S_LCNT;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pre_status_reg;
                    m_cell_x_next = cx_reg;
                    m_cell_y_next = cy_reg;
                    m_hit_next    = '0;
                    m_on_next     = 1'b0;
                    m_off_next    = 1'b0;
                    state_next    = S_IDLE;
                    if (pre_status_reg == ST_SKIPPED || pre_status_reg == ST_BAD_INDEX) begin
                        m_cell_x_next = '0;
                        m_cell_y_next = '0;
                    end else if (pre_status_reg == ST_OK) begin
                        if (kind_reg == KIND_ADD) begin
                            if (c == '1) begin
                                m_status_next = ST_SATURATED;
                                m_hit_next    = hit_out(c);
                            end else begin
                                cnt_we     = 1'b1;
                                cnt_wdata  = count_t'(c + count_t'(1));
                                m_hit_next = hit_out(cnt_wdata);
                                if (c == '0 && size_reg < size_t'(CELLS)) begin
                                    pos_we     = 1'b1;
                                    pos_wdata  = cell_t'(size_reg);
                                    list_we    = 1'b1;
                                    list_waddr = cell_t'(size_reg);
                                    list_wdata = flat_reg;
                                    size_next  = size_t'(size_reg + size_t'(1));
                                    m_on_next  = 1'b1;
                                end
                            end
                        end else begin
                            if (c == '0) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                cnt_we     = 1'b1;
                                cnt_wdata  = count_t'(c - count_t'(1));
                                m_hit_next = hit_out(cnt_wdata);
                                if (cnt_wdata == '0) begin
                                    list_we    = 1'b1;
                                    list_waddr = pos_rdata_reg;
                                    list_wdata = list_rdata_reg;
                                    pos_we     = 1'b1;
                                    pos_waddr  = list_rdata_reg;
                                    pos_wdata  = pos_rdata_reg;
                                    size_next  = size_t'(size_reg - size_t'(1));
                                    m_off_next = 1'b1;
                                end
                            end
                        end
                    end
                    m_total_next = total_out(size_next);
                end
            end
            S_LCNT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_cell_x_next = origin_x_reg + COORD_W'(flat_reg[LOG2-1:0]);
                    m_cell_y_next = origin_y_reg + COORD_W'(flat_reg[CELL_BITS-1:LOG2]);
                    m_hit_next    = hit_out(c);
                    m_total_next  = total_out(size_reg);
                    m_on_next     = 1'b0;
                    m_off_next    = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            size_reg     <= '0;
            m_valid_reg  <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            shift_reg    <= CELL_SHIFT_RESET;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            size_reg     <= size_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ORIGIN_X:   origin_x_reg <= cfg_data;
                    REG_ORIGIN_Y:   origin_y_reg <= cfg_data;
                    REG_CELL_SHIFT: shift_reg    <= cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg   <= s_kind;
            finite_reg <= s_finite;
            index_reg  <= s_list_index;
            cx_reg     <= s_point_x >>> shift_reg;
            cy_reg     <= s_point_y >>> shift_reg;
        end
        pre_status_reg <= pre_status_next;
        flat_reg       <= flat_next;
        m_status_reg   <= m_status_next;
        m_cell_x_reg   <= m_cell_x_next;
        m_cell_y_reg   <= m_cell_y_next;
        m_hit_reg      <= m_hit_next;
        m_total_reg    <= m_total_next;
        m_on_reg       <= m_on_next;
        m_off_reg      <= m_off_next;
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_re) begin
            pos_rdata_reg <= pos_mem[pos_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (list_re) begin
            list_rdata_reg <= list_mem[list_raddr];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_cell_x          = m_cell_x_reg;
    assign m_cell_y          = m_cell_y_reg;
    assign m_hit_count       = m_hit_reg;
    assign m_active_total    = m_total_reg;
    assign m_became_active   = m_on_reg;
    assign m_became_inactive = m_off_reg;

endmodule

### hdl/hcgas_checker.sv
// Port-level checks for the hit-count grid, bound to the top level.
module hcgas_checker
    import hcgas_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [STATUS_W-1:0]    m_status,
    input logic signed [COORD_W-1:0] m_cell_x,
    input logic signed [COORD_W-1:0] m_cell_y,
    input logic [HIT_OUT_W-1:0]   m_hit_count,
    input logic [TOTAL_W-1:0]     m_active_total,
    input logic                   m_became_active,
    input logic                   m_became_inactive
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_hit_count)
                                && $stable(m_active_total))
        else $error("result beat changed while stalled");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_became_active && m_became_inactive))
        else $error("cell both appended and removed");

    a_append: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_became_active |-> m_status == ST_OK && m_hit_count == 16'd1
                                       && m_active_total != '0)
        else $error("append without first hit");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_became_inactive |-> m_status == ST_OK && m_hit_count == '0)
        else $error("removal with non-zero count");

    a_void: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_SKIPPED || m_status == ST_BAD_INDEX)
            |-> m_hit_count == '0 && m_cell_x == '0 && m_cell_y == '0)
        else $error("skipped or bad-index beat carries data");

endmodule

bind hit_count_grid_active_set hcgas_checker u_hcgas_checker (.*);

### test/hit_count_grid_active_set_test.sv
// Self-checking testbench for the hit-count grid with its sparse active-cell list.
module hit_count_grid_active_set_test
    import hcgas_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE         = 1 << GRID_SIDE_LOG2;
    localparam int COUNT_TOP    = (1 << COUNT_BITS) - 1;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 16;

    localparam kind_t  KIND_SPARE = 2'd3;
    localparam coord_t COORD_MIN  = -24'sd8388608;
    localparam coord_t COORD_MAX  = 24'sd8388607;

    typedef struct packed {
        kind_t               kind;
        coord_t              x;
        coord_t              y;
        logic                fin;
        logic [INDEX_W-1:0]  idx;
    } point_item_t;

    typedef struct packed {
        status_t               status;
        coord_t                cell_x;
        coord_t                cell_y;
        logic [HIT_OUT_W-1:0]  hits;
        logic [TOTAL_W-1:0]    total;
        logic                  on;
        logic                  off;
    } grid_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data = '0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [KIND_W-1:0]      s_kind = '0;
    coord_t                 s_point_x = '0;
    coord_t                 s_point_y = '0;
    logic                   s_finite = 1'b0;
    logic [INDEX_W-1:0]     s_list_index = '0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    coord_t                 m_cell_x;
    coord_t                 m_cell_y;
    logic [HIT_OUT_W-1:0]   m_hit_count;
    logic [TOTAL_W-1:0]     m_active_total;
    logic                   m_became_active;
    logic                   m_became_inactive;

    // window registers as the block should hold them
    coord_t                 win_org_x;
    coord_t                 win_org_y;
    logic [SHIFT_W-1:0]     win_shift;

    // predicted grid contents
    bit [COUNT_BITS-1:0]    grid_hits [CELLS];
    int                     slot_of [CELLS];
    int                     list_cells [CELLS];
    int                     live_count;

    // stimulus-side tally, used to aim adds, removes and list reads
    int                     gen_tally [CELLS];
    int                     gen_live [$];

    point_item_t            pending_items [$];
    grid_result_t           expected_outcomes [$];
    point_item_t            next_item;
    point_item_t            seen_item;
    grid_result_t           want;

    bit                     idling;
    int                     send_gap;
    int                     stall_left;
    int                     fail_count;
    int                     beats_in;
    int                     results_checked;
    int                     settings_count;
    int                     cycle_count;

    hit_count_grid_active_set u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .s_finite          (s_finite),
        .s_list_index      (s_list_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_cell_x          (m_cell_x),
        .m_cell_y          (m_cell_y),
        .m_hit_count       (m_hit_count),
        .m_active_total    (m_active_total),
        .m_became_active   (m_became_active),
        .m_became_inactive (m_became_inactive)
    );

    always #6 aclk = ~aclk;

    function automatic bit locate(input coord_t px, input coord_t py,
                                  output coord_t cx, output coord_t cy, output int flat);
        int lx;
        int ly;
        cx = px >>> win_shift;
        cy = py >>> win_shift;
        lx = int'(cx) - int'(win_org_x);
        ly = int'(cy) - int'(win_org_y);
        flat = ly * SIDE + lx;
        return lx >= 0 && lx < SIDE && ly >= 0 && ly < SIDE;
    endfunction

    function automatic grid_result_t grid_apply(input point_item_t it);
        grid_result_t        r;
        coord_t              cx;
        coord_t              cy;
        int                  flat;
        int                  slot;
        int                  tail;
        bit [COUNT_BITS-1:0] c;
        r = '0;
        r.status = ST_SKIPPED;
        if (it.kind == KIND_READ) begin
            if (int'(it.idx) >= live_count) begin
                r.status = ST_BAD_INDEX;
            end else begin
                slot = list_cells[it.idx];
                r.status = ST_OK;
                r.cell_x = win_org_x + coord_t'(slot % SIDE);
                r.cell_y = win_org_y + coord_t'(slot / SIDE);
                r.hits = HIT_OUT_W'(grid_hits[slot]);
            end
        end else if (it.kind != KIND_SPARE && it.fin) begin
            if (!locate(it.x, it.y, cx, cy, flat)) begin
                r.status = ST_OUTSIDE;
                r.cell_x = cx;
                r.cell_y = cy;
            end else begin
                c = grid_hits[flat];
                r.status = ST_OK;
                r.cell_x = cx;
                r.cell_y = cy;
                if (it.kind == KIND_ADD) begin
                    if (&c) begin
                        r.status = ST_SATURATED;
                        r.hits = HIT_OUT_W'(c);
                    end else begin
                        if (c == 0) begin
                            slot_of[flat] = live_count;
                            list_cells[live_count] = flat;
                            live_count++;
                            r.on = 1'b1;
                        end
                        grid_hits[flat] = c + 1'b1;
                        r.hits = HIT_OUT_W'(c + 1'b1);
                    end
                end else if (c == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    grid_hits[flat] = c - 1'b1;
                    r.hits = HIT_OUT_W'(c - 1'b1);
                    if (c == 1) begin
                        // last entry of the list fills the freed slot
                        slot = slot_of[flat];
                        tail = list_cells[live_count - 1];
                        list_cells[slot] = tail;
                        slot_of[tail] = slot;
                        live_count--;
                        r.off = 1'b1;
                    end
                end
            end
        end
        r.total = TOTAL_W'(live_count);
        return r;
    endfunction

    function automatic void queue_item(input kind_t k, input coord_t x, input coord_t y,
                                       input logic fin, input logic [INDEX_W-1:0] idx);
        point_item_t it;
        coord_t      cx;
        coord_t      cy;
        int          flat;
        int          i;
        it = {k, x, y, fin, idx};
        pending_items.insert(pending_items.size(), it);
        if ((k == KIND_ADD || k == KIND_REMOVE) && fin && locate(x, y, cx, cy, flat)) begin
            if (k == KIND_ADD && gen_tally[flat] < COUNT_TOP) begin
                if (gen_tally[flat] == 0)
                    gen_live.insert(gen_live.size(), flat);
                gen_tally[flat]++;
            end else if (k == KIND_REMOVE && gen_tally[flat] > 0) begin
                gen_tally[flat]--;
                if (gen_tally[flat] == 0) begin
                    for (i = 0; i < gen_live.size(); i++) begin
                        if (gen_live[i] == flat) begin
                            gen_live.delete(i);
                            break;
                        end
                    end
                end
            end
        end
    endfunction

    // a point that lands in window slot flat, if the coordinate range allows one
    function automatic bit point_in_slot(input int flat, output coord_t px, output coord_t py);
        longint cx;
        longint cy;
        longint lim;
        cx = longint'(win_org_x) + (flat % SIDE);
        cy = longint'(win_org_y) + (flat / SIDE);
        lim = longint'(1) <<< (COORD_W - 1 - int'(win_shift));
        px = coord_t'((cx <<< win_shift) + $urandom_range(0, (1 << win_shift) - 1));
        py = coord_t'((cy <<< win_shift) + $urandom_range(0, (1 << win_shift) - 1));
        return cx >= -lim && cx < lim && cy >= -lim && cy < lim;
    endfunction

    function automatic void queue_random_items(input int n);
        int     r;
        int     flat;
        int     j;
        coord_t px;
        coord_t py;
        kind_t  k;
        logic [INDEX_W-1:0] idx;
        for (j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            idx = INDEX_W'($urandom);
            k = ($urandom_range(0, 1) != 0) ? KIND_REMOVE : KIND_ADD;
            if (r < 70) begin
                k = (r < 40) ? KIND_ADD : KIND_REMOVE;
                if (gen_live.size() > 0 && $urandom_range(0, 9) < 7)
                    flat = gen_live[$urandom_range(0, gen_live.size() - 1)];
                else
                    flat = $urandom_range(0, CELLS - 1);
                if (!point_in_slot(flat, px, py)) begin
                    px = coord_t'($urandom);
                    py = coord_t'($urandom);
                end
                queue_item(k, px, py, 1'b1, idx);
            end else begin
                px = coord_t'($urandom);
                py = coord_t'($urandom);
                if (r < 85) begin
                    if (gen_live.size() > 0 && $urandom_range(0, 4) != 0)
                        idx = INDEX_W'($urandom_range(0, gen_live.size() - 1));
                    queue_item(KIND_READ, px, py, 1'($urandom), idx);
                end else if (r < 93) begin
                    queue_item(k, px, py, 1'b1, idx);
                end else if (r < 98) begin
                    queue_item(k, px, py, 1'b0, idx);
                end else begin
                    queue_item(KIND_SPARE, px, py, 1'($urandom), idx);
                end
            end
        end
    endfunction

    function automatic void check_field(input string label, input logic signed [63:0] exp_v,
                                        input logic signed [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, exp_v, got_v);
            fail_count++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel, input logic [COORD_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (sel)
            REG_ORIGIN_X:   win_org_x = data;
            REG_ORIGIN_Y:   win_org_y = data;
            REG_CELL_SHIFT: win_shift = data[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_window(input coord_t ox, input coord_t oy, input logic [SHIFT_W-1:0] sh);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_SHIFT, COORD_W'(sh));
        settings_count++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_outcomes.size() != 0)
            @(negedge aclk);
    endtask

    // input channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                seen_item = {s_kind, s_point_x, s_point_y, s_finite, s_list_index};
                expected_outcomes.insert(expected_outcomes.size(), grid_apply(seen_item));
                beats_in++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0 && idling && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    s_valid      <= 1'b1;
                    s_kind       <= next_item.kind;
                    s_point_x    <= next_item.x;
                    s_point_y    <= next_item.y;
                    s_finite     <= next_item.fin;
                    s_list_index <= next_item.idx;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, status %0d",
                             $time, m_status);
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("cell_x", $signed(want.cell_x), m_cell_x);
                    check_field("cell_y", $signed(want.cell_y), m_cell_y);
                    check_field("hit_count", want.hits, m_hit_count);
                    check_field("active_total", want.total, m_active_total);
                    check_field("became_active", want.on, m_became_active);
                    check_field("became_inactive", want.off, m_became_inactive);
                    results_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timed out with %0d results outstanding", $time,
                     expected_outcomes.size());
            $display("FAIL hit_count_grid_active_set");
            $finish;
        end
    end

    initial begin
        win_org_x = '0;
        win_org_y = '0;
        win_shift = CELL_SHIFT_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // cells of 16 units, window corner at cell (-2, -3)
        idling = 1'b1;
        set_window(-24'sd2, -24'sd3, 4'd4);
        queue_item(KIND_ADD, -24'sd32, -24'sd48, 1'b1, '0);
        queue_item(KIND_ADD, -24'sd17, -24'sd33, 1'b1, '0);
        queue_item(KIND_ADD, 24'sd991, 24'sd975, 1'b1, '0);
        queue_item(KIND_ADD, 24'sd992, 24'sd975, 1'b1, '0);
        queue_item(KIND_ADD, -24'sd33, -24'sd48, 1'b1, '0);
        queue_item(KIND_ADD, COORD_MAX, COORD_MIN, 1'b1, '0);
        queue_item(KIND_REMOVE, COORD_MIN, COORD_MAX, 1'b1, '1);
        queue_item(KIND_ADD, 24'sd100, 24'sd200, 1'b0, '0);
        queue_item(KIND_REMOVE, -24'sd32, -24'sd48, 1'b0, '0);
        queue_item(KIND_SPARE, -24'sd32, -24'sd48, 1'b1, 12'd1);
        queue_item(KIND_READ, '0, '0, 1'b0, 12'd0);
        queue_item(KIND_READ, COORD_MIN, COORD_MAX, 1'b1, 12'd1);
        queue_item(KIND_READ, '0, '0, 1'b0, 12'd2);
        queue_item(KIND_READ, '0, '0, 1'b1, '1);
        queue_item(KIND_ADD, '0, '0, 1'b1, '0);
        queue_item(KIND_REMOVE, -24'sd32, -24'sd48, 1'b1, '0);
        queue_item(KIND_REMOVE, -24'sd20, -24'sd40, 1'b1, '0);
        queue_item(KIND_REMOVE, -24'sd32, -24'sd48, 1'b1, '0);
        queue_item(KIND_READ, '0, '0, 1'b0, 12'd0);
        queue_item(KIND_READ, '0, '0, 1'b0, 12'd2);
        queue_item(KIND_REMOVE, 24'sd991, 24'sd975, 1'b1, '0);
        queue_item(KIND_READ, '0, '0, 1'b0, 12'd0);
        queue_item(KIND_READ, '0, '0, 1'b0, 12'd1);
        queue_random_items(60);
        wait_drained();
        queue_random_items(60);

        wait_drained();
        set_window(COORD_MIN, 24'sd8388544, 4'd0);
        queue_random_items(100);

        wait_drained();
        set_window(-24'sd40, 24'sd200, 4'd15);
        queue_random_items(100);

        // window hangs off the top of the x range; list reads wrap
        wait_drained();
        set_window(COORD_MAX, COORD_MIN, 4'd0);
        queue_random_items(60);

        wait_drained();
        idling = 1'b0;
        set_window(24'sd5, -24'sd7, 4'd2);
        queue_random_items(150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d input beats, %0d results checked over %0d window settings",
                 beats_in, results_checked, settings_count);
        $display("covered skipped, outside, empty and bad-index cases, list reads and swap removals");
        if (fail_count == 0) begin
            $display("PASS hit_count_grid_active_set");
        end else begin
            $display("FAIL hit_count_grid_active_set");
        end
        $finish;
    end

endmodule

### hit_count_grid_active_set.f
hdl/hcgas_pkg.sv
hdl/hit_count_grid_active_set.sv
hdl/hcgas_checker.sv
test/hit_count_grid_active_set_test.sv
